/* design/utf8v_pkg.sv */
// Package: shared types and constants for the UTF-8 stream validator.
`default_nettype none

package utf8v_pkg;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  // Continuation byte pattern 10xxxxxx
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3F;

  // Code point limits
  localparam logic [20:0] CP_MIN3 = 21'h000800;
  localparam logic [20:0] CP_MIN4 = 21'h010000;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  // Sequence length codes
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  pending;
    logic [2:0]  seq_len;
    logic [20:0] partial;
    logic        sticky;
  } dec_state_t;

  // Per-byte result
  typedef struct packed {
    logic error_so_far;
    logic string_done;
    logic string_valid;
  } dec_result_t;

endpackage

`default_nettype wire

/* design/utf8_stream_validator.sv */
// Path from input request to result: input register, then result register.
// Throughput: one byte per cycle while no side stalls; per-byte decode is one shallow
// combinational step. Either side may stall; a full result register does not block
// input while it drains. Reset (rst, synchronous, active high) empties both registers
// and clears the decoder state and sticky error.
`default_nettype none

module utf8_stream_validator (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  wire logic       s_axis_tlast,   // last_byte
  // Result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [0] error_so_far, [1] string_valid, [7:2] zero
  output logic            m_axis_tlast    // string_done
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Result register
  logic                  out_valid;
  utf8v_pkg::dec_result_t out_result;

  // Decoder state
  utf8v_pkg::dec_state_t  state;
  utf8v_pkg::dec_state_t  state_next;
  utf8v_pkg::dec_result_t step_result;

  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register: take a request whenever it is empty or the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  utf8v_decode u_decode (
    .state      (state),
    .byte_value (in_byte),
    .last_byte  (in_last),
    .state_next (state_next),
    .result     (step_result)
  );

  // Decoder state advances with each byte that enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_result.string_valid, out_result.error_so_far};
  assign m_axis_tlast  = out_result.string_done;

`ifndef SYNTHESIS
  // A closed string leaves no open sequence and no error behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (state == '0))
    else $error("decoder state not cleared after last byte");

  // Open sequence length and pending count agree
  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (state.pending == 2'd0) == (state.seq_len == utf8v_pkg::SEQ_NONE))
    else $error("pending count and sequence length disagree");

  // A valid verdict only on a closing result with no error
  a_valid_verdict: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tlast && !m_axis_tdata[0]))
    else $error("string_valid without clean close");
`endif

endmodule

`default_nettype wire

/* design/utf8v_decode.sv */
// Per-byte UTF-8 decode step: next state and result from current state and byte.
`default_nettype none

module utf8v_decode (
  input  wire utf8v_pkg::dec_state_t  state,
  input  wire logic [7:0]             byte_value,
  input  wire logic                   last_byte,
  output utf8v_pkg::dec_state_t       state_next,
  output utf8v_pkg::dec_result_t      result
);

  utf8v_pkg::dec_state_t st;
  logic [20:0] cp;
  logic [1:0]  pend_dec;
  logic        fail;

  always_comb begin
    st       = state;
    fail     = 1'b0;
    cp       = {state.partial[14:0], byte_value[5:0] & utf8v_pkg::CONT_PAYLOAD[5:0]};
    pend_dec = state.pending - 2'd1;

    if (state.pending == 2'd0) begin
      // Expecting a lead byte
      priority if (byte_value == utf8v_pkg::NUL_BYTE) begin
        fail = 1'b1;
      end else if (byte_value <= utf8v_pkg::ASCII_MAX) begin
        st = state;
      end else if (byte_value >= utf8v_pkg::LEAD2_MIN &&
                   byte_value <= utf8v_pkg::LEAD2_MAX) begin
        st.seq_len = utf8v_pkg::SEQ_TWO;
        st.pending = 2'd1;
        st.partial = {16'd0, byte_value[4:0]};
      end else if (byte_value >= utf8v_pkg::LEAD3_MIN &&
                   byte_value <= utf8v_pkg::LEAD3_MAX) begin
        st.seq_len = utf8v_pkg::SEQ_THREE;
        st.pending = 2'd2;
        st.partial = {17'd0, byte_value[3:0]};
      end else if (byte_value >= utf8v_pkg::LEAD4_MIN &&
                   byte_value <= utf8v_pkg::LEAD4_MAX) begin
        st.seq_len = utf8v_pkg::SEQ_FOUR;
        st.pending = 2'd3;
        st.partial = {18'd0, byte_value[2:0]};
      end else begin
        fail = 1'b1;
      end
    end else begin
      // Expecting a continuation byte
      if ((byte_value & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) begin
        fail = 1'b1;
      end else begin
        st.partial = cp;
        st.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          // Sequence complete: reject overlong, surrogate and out-of-range forms
          if ((state.seq_len == utf8v_pkg::SEQ_THREE && cp < utf8v_pkg::CP_MIN3) ||
              (state.seq_len == utf8v_pkg::SEQ_FOUR && cp < utf8v_pkg::CP_MIN4) ||
              (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI) ||
              (cp > utf8v_pkg::CP_MAX)) begin
            fail = 1'b1;
          end else begin
            st.seq_len = utf8v_pkg::SEQ_NONE;
            st.partial = '0;
          end
        end
      end
    end

    // Sequence cut short by end of string
    if (last_byte && st.pending != 2'd0) begin
      fail = 1'b1;
    end

    if (fail) begin
      st.sticky  = 1'b1;
      st.pending = 2'd0;
      st.seq_len = utf8v_pkg::SEQ_NONE;
      st.partial = '0;
    end

    result.error_so_far = st.sticky;
    result.string_done  = last_byte;
    result.string_valid = last_byte & ~st.sticky;

    // Verdict given; clear for the next string
    if (last_byte) begin
      state_next = '0;
    end else begin
      state_next = st;
    end
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the UTF-8 stream validator: directed strings, random strings, scoreboard.
`default_nettype none

module testbench;

  localparam logic [2:0] SEQ_ONE = 3'd1;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 125;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // Stream signals; those the bench drives are known from time zero
  logic       s_valid = 1'b0;
  logic [7:0] s_data  = 8'h00;
  logic       s_last  = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic       m_last;

  utf8_stream_validator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  // Idle and stall odds, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Decoder state mirrored by the predictor
  logic [1:0]  exp_pending = 2'd0;
  logic [2:0]  exp_seq_len = utf8v_pkg::SEQ_NONE;
  logic [20:0] exp_partial = 21'd0;
  logic        exp_sticky  = 1'b0;

  utf8v_pkg::dec_result_t expected_results[$];
  logic [7:0]             string_bytes[$];

  int failures       = 0;
  int bytes_sent     = 0;
  int strings_sent   = 0;
  int results_seen   = 0;
  int strings_passed = 0;

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic void drop_open_sequence();
    exp_pending = 2'd0;
    exp_seq_len = utf8v_pkg::SEQ_NONE;
    exp_partial = 21'd0;
  endfunction

  function automatic void flag_encoding_error();
    exp_sticky = 1'b1;
    drop_open_sequence();
  endfunction

  // Advance the mirrored decoder by one byte and return the verdict for it
  function automatic utf8v_pkg::dec_result_t predict_utf8(input logic [7:0] b,
                                                          input logic last);
    utf8v_pkg::dec_result_t r;
    logic [20:0] cp;
    if (exp_pending == 2'd0) begin
      if (b == utf8v_pkg::NUL_BYTE) begin
        flag_encoding_error();
      end else if (b <= utf8v_pkg::ASCII_MAX) begin
        // stand-alone character
      end else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX) begin
        exp_seq_len = utf8v_pkg::SEQ_TWO;
        exp_pending = 2'd1;
        exp_partial = {16'd0, b[4:0]};
      end else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX) begin
        exp_seq_len = utf8v_pkg::SEQ_THREE;
        exp_pending = 2'd2;
        exp_partial = {17'd0, b[3:0]};
      end else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX) begin
        exp_seq_len = utf8v_pkg::SEQ_FOUR;
        exp_pending = 2'd3;
        exp_partial = {18'd0, b[2:0]};
      end else begin
        flag_encoding_error();
      end
    end else if ((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) begin
      flag_encoding_error();
    end else begin
      cp = {exp_partial[14:0], b[5:0]};
      exp_partial = cp;
      exp_pending = exp_pending - 2'd1;
      if (exp_pending == 2'd0) begin
        if ((exp_seq_len == utf8v_pkg::SEQ_THREE && cp < utf8v_pkg::CP_MIN3) ||
            (exp_seq_len == utf8v_pkg::SEQ_FOUR && cp < utf8v_pkg::CP_MIN4) ||
            (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI) ||
            cp > utf8v_pkg::CP_MAX) begin
          flag_encoding_error();
        end else begin
          drop_open_sequence();
        end
      end
    end
    // open sequence at end of string
    if (last && exp_pending != 2'd0) flag_encoding_error();
    r.error_so_far = exp_sticky;
    r.string_done  = last;
    r.string_valid = last && !exp_sticky;
    if (last) begin
      drop_open_sequence();
      exp_sticky = 1'b0;
    end
    return r;
  endfunction

  // Receiver stall pattern
  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    utf8v_pkg::dec_result_t want;
    if (!rst && m_valid && m_ready) begin
      results_seen++;
      if (m_last && m_data[1]) strings_passed++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: data=%02h last=%0b", m_data, m_last));
      end else begin
        want = expected_results.pop_front();
        if (m_data[0] !== want.error_so_far)
          note_failure($sformatf("result %0d error_so_far: expected %0b actual %0b",
                                 results_seen, want.error_so_far, m_data[0]));
        if (m_data[1] !== want.string_valid)
          note_failure($sformatf("result %0d string_valid: expected %0b actual %0b",
                                 results_seen, want.string_valid, m_data[1]));
        if (m_last !== want.string_done)
          note_failure($sformatf("result %0d string_done: expected %0b actual %0b",
                                 results_seen, want.string_done, m_last));
        if (m_data[7:2] !== 6'd0)
          note_failure($sformatf("result %0d padding: expected 00 actual %02h",
                                 results_seen, m_data[7:2]));
      end
    end
  end

  // Send one byte request, with a random gap before it, and log its expectation
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    expected_results.insert(expected_results.size(), predict_utf8(b, last));
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_results_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_string_bytes();
    foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  // Add one byte at the end of the string being built
  function automatic void add_string_byte(input logic [7:0] b);
    string_bytes.insert(string_bytes.size(), b);
  endfunction

  // Encode a code point with a chosen length; overlong and out-of-range on purpose
  function automatic void push_encoded(input logic [20:0] cp, input logic [2:0] len);
    case (len)
      SEQ_ONE: begin
        add_string_byte({1'b0, cp[6:0]});
      end
      utf8v_pkg::SEQ_TWO: begin
        add_string_byte({3'b110, cp[10:6]});
        add_string_byte({2'b10, cp[5:0]});
      end
      utf8v_pkg::SEQ_THREE: begin
        add_string_byte({4'b1110, cp[15:12]});
        add_string_byte({2'b10, cp[11:6]});
        add_string_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_string_byte({5'b11110, cp[20:18]});
        add_string_byte({2'b10, cp[17:12]});
        add_string_byte({2'b10, cp[11:6]});
        add_string_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Append one character; clean strings skip the error classes, yet may hold surrogates
  function automatic void append_char(input logic clean);
    int kind;
    int cut;
    logic [2:0] len;
    kind = clean ? $urandom_range(69) : $urandom_range(99);
    if (kind < 20) begin
      push_encoded(21'($urandom_range(8'h01, 8'h7F)), SEQ_ONE);
    end else if (kind < 35) begin
      push_encoded(21'($urandom_range(16'h0080, 16'h07FF)), utf8v_pkg::SEQ_TWO);
    end else if (kind < 55) begin
      push_encoded(21'($urandom_range(16'h0800, 16'hFFFF)), utf8v_pkg::SEQ_THREE);
    end else if (kind < 70) begin
      push_encoded(21'($urandom_range(21'h010000, 21'h10FFFF)), utf8v_pkg::SEQ_FOUR);
    end else if (kind < 76) begin
      push_encoded(21'($urandom_range(16'hD800, 16'hDFFF)), utf8v_pkg::SEQ_THREE);
    end else if (kind < 82) begin
      // overlong forms
      case ($urandom_range(2))
        0: push_encoded(21'($urandom_range(8'h7F)), utf8v_pkg::SEQ_TWO);
        1: push_encoded(21'($urandom_range(16'h07FF)), utf8v_pkg::SEQ_THREE);
        default: push_encoded(21'($urandom_range(16'hFFFF)), utf8v_pkg::SEQ_FOUR);
      endcase
    end else if (kind < 86) begin
      push_encoded(21'($urandom_range(21'h110000, 21'h1FFFFF)), utf8v_pkg::SEQ_FOUR);
    end else if (kind < 92) begin
      add_string_byte(($urandom_range(7) == 0) ? utf8v_pkg::NUL_BYTE : 8'($urandom));
    end else begin
      // sequence cut short
      len = 3'($urandom_range(2, 4));
      push_encoded(21'($urandom), len);
      cut = $urandom_range(1, len - 1);
      repeat (cut) void'(string_bytes.pop_back());
    end
  endfunction

  task automatic test_ascii_and_nul();
    send_byte(8'h41, 1'b1);
    // NUL, then a later byte that cannot clear the error
    send_byte(utf8v_pkg::NUL_BYTE, 1'b0);
    send_byte(utf8v_pkg::ASCII_MAX, 1'b1);
  endtask

  task automatic test_two_byte_extremes();
    send_byte(utf8v_pkg::LEAD2_MIN, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(utf8v_pkg::LEAD2_MAX, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_three_byte_rules();
    // overlong
    send_byte(utf8v_pkg::LEAD3_MIN, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b1);
    // surrogate
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_four_byte_rules();
    // highest code point, with a full drain in the middle of the sequence
    send_byte(utf8v_pkg::LEAD4_MAX, 1'b0);
    wait_results_drained();
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // just above the highest code point
    send_byte(utf8v_pkg::LEAD4_MAX, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_error_recovery();
    // bad continuation, next byte decoded as a lead
    send_byte(utf8v_pkg::LEAD2_MIN, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_truncation();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int start_bytes;
    wait_results_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < PHASE_BYTES) begin
      repeat ($urandom_range(1, 6)) append_char($urandom_range(1) == 1);
      send_string_bytes();
    end
  endtask

  // Run timeout
  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_ascii_and_nul();
    test_two_byte_extremes();
    test_three_byte_rules();
    test_four_byte_rules();
    test_error_recovery();
    test_truncation();
    test_random_phase(0, 0);
    test_random_phase(86, 0);
    test_random_phase(0, 86);
    test_random_phase(17, 17);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d strings in %0d bytes over four idle/stall phases;",
             strings_sent, bytes_sent);
    $display("%0d results checked, %0d strings judged valid, %0d failures.",
             results_seen, strings_passed, failures);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/utf8v_pkg.sv
design/utf8v_decode.sv
design/utf8_stream_validator.sv
sim/testbench.sv
